@@ hw/rtl/ifre_pkg.sv @@
// shared types, constants and helpers for the image flip/rotate engine
// used by ifre_frame_store and image_flip_rotate_engine_unit; no dependencies
package ifre_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int COORD_W     = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
		$clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
	localparam int SIZE_W      = 9;
	localparam int COUNT_W     = 2 * SIZE_W - 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = SIZE_W;
	localparam int MODE_W      = 2;

	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_MIRROR  = 2'd0,
		MODE_REVERSE = 2'd1,
		MODE_ROT_L   = 2'd2,
		MODE_ROT_R   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		pixel_t data;
	} store_wr_t;

	localparam size_t SIZE_MAX_W = size_t'(MAX_WIDTH);
	localparam size_t SIZE_MAX_H = size_t'(MAX_HEIGHT);

	// zero acts as one, oversize acts as the maximum
	function automatic size_t clamp_size(input size_t v, input size_t max_v);
		size_t res;
		if (v == '0) begin
			res = size_t'(1);
		end else if (v > max_v) begin
			res = max_v;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/ifre_frame_store.sv @@
// frame store: one write port, one registered read port (read-first)
// depends on ifre_pkg
module ifre_frame_store
	import ifre_pkg::*;
(
	input  logic      clk,
	input  store_wr_t wr,
	input  logic      rd_en,
	input  addr_t     rd_addr,
	output pixel_t    rd_data
);

	pixel_t mem [STORE_DEPTH];
	pixel_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/image_flip_rotate_engine_unit.sv @@
// image flip/rotate engine: loads a frame into a 64k x 24 store, emits it transformed
// load beat: written to the store at its accept edge, no result
// emit beat: result registered through the address register, then the store read port
// one beat per cycle on input; a stalled output holds the read stage and then the input
// arst_n clears counters, pipeline valids and config (256 x 256, mirror); store is not cleared
module image_flip_rotate_engine_unit
	import ifre_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic                  last_pixel
);

	size_t  width_q, height_q;
	mode_t  mode_q;
	count_t load_count_q;
	logic   frame_full_q;
	coord_t emit_row_q, emit_col_q;

	logic   valid_s1, last_s1;
	addr_t  addr_s1;
	logic   out_valid_q, last_q;

	size_t  w_cl, h_cl, ow, oh, oh_m1, ow_m1;
	count_t total, count_nxt, addr_full;
	logic   rotated, load_fits, in_acc, load_acc, emit_acc, last_now, s1_adv;
	coord_t r, c, sr, sc;
	size_t  c_inc;
	store_wr_t wr;
	pixel_t rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_MAX_W;
			height_q <= SIZE_MAX_H;
			mode_q   <= MODE_MIRROR;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q   <= mode_t'(cfg_data[MODE_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		w_cl    = clamp_size(width_q, SIZE_MAX_W);
		h_cl    = clamp_size(height_q, SIZE_MAX_H);
		total   = count_t'(w_cl) * count_t'(h_cl);
		rotated = (mode_q == MODE_ROT_L) || (mode_q == MODE_ROT_R);
		ow      = rotated ? h_cl : w_cl;
		oh      = rotated ? w_cl : h_cl;
		ow_m1   = ow - size_t'(1);
		oh_m1   = oh - size_t'(1);

		// saturate the emit position to the current output frame
		r = (size_t'(emit_row_q) < oh) ? emit_row_q : oh_m1[COORD_W-1:0];
		c = (size_t'(emit_col_q) < ow) ? emit_col_q : ow_m1[COORD_W-1:0];

		case (mode_q)
			MODE_MIRROR: begin
				sr = r;
				sc = coord_t'(w_cl - size_t'(1) - size_t'(c));
			end
			MODE_REVERSE: begin
				sr = coord_t'(h_cl - size_t'(1) - size_t'(r));
				sc = c;
			end
			MODE_ROT_L: begin
				sr = coord_t'(h_cl - size_t'(1) - size_t'(c));
				sc = r;
			end
			default: begin
				sr = c;
				sc = coord_t'(w_cl - size_t'(1) - size_t'(r));
			end
		endcase

		addr_full = count_t'(sr) * count_t'(w_cl) + count_t'(sc);
		last_now  = (size_t'(r) == oh_m1) && (size_t'(c) == ow_m1);
		c_inc     = size_t'(c) + size_t'(1);

		load_fits = load_count_q < total;
		count_nxt = load_count_q + (load_fits ? count_t'(1) : count_t'(0));
	end

	// s1 moves into the output register unless a result is stuck there
	assign s1_adv   = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && !kind && !frame_full_q;
	assign emit_acc = in_acc && kind && frame_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			frame_full_q <= 1'b0;
			emit_row_q   <= '0;
			emit_col_q   <= '0;
		end else if (load_acc) begin
			load_count_q <= count_nxt;
			frame_full_q <= count_nxt >= total;
		end else if (emit_acc) begin
			if (last_now) begin
				load_count_q <= '0;
				frame_full_q <= 1'b0;
				emit_row_q   <= '0;
				emit_col_q   <= '0;
			end else if (c_inc >= ow) begin
				emit_col_q <= '0;
				emit_row_q <= r + coord_t'(1);
			end else begin
				emit_col_q <= c_inc[COORD_W-1:0];
				emit_row_q <= r;
			end
		end
	end

	// s1 takes a new beat whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= emit_acc;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			addr_s1 <= addr_full[ADDR_W-1:0];
			last_s1 <= last_now;
		end
		if (s1_adv && valid_s1) begin
			last_q <= last_s1;
		end
	end

	always_comb begin
		wr.en   = load_acc && load_fits;
		wr.addr = load_count_q[ADDR_W-1:0];
		wr.data = '{red: red_in, green: green_in, blue: blue_in};
	end

	ifre_frame_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (s1_adv && valid_s1),
		.rd_addr (addr_s1),
		.rd_data (rd_data)
	);

	assign out_valid  = out_valid_q;
	assign red_out    = rd_data.red;
	assign green_out  = rd_data.green;
	assign blue_out   = rd_data.blue;
	assign last_pixel = last_q;

endmodule
